>>> hdl/ntpcal_pkg.sv
// Shared constants, types and the month length table of the NTP to calendar converter.
`default_nettype none
package ntpcal_pkg;

    // Field widths.
    localparam int RAW_W   = 32;
    localparam int TZ_W    = 18;
    localparam int YEAR_W  = 8;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Seconds from 1900-01-01 to 1970-01-01.
    localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;

    // Day counting runs from 1968-01-01, the start of a leap-year group of four.
    localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
    localparam logic [31:0] DAYS_PER_QUAD     = 32'd1461;
    // First day after 2100-02-28, counted from 1970; from here one phantom day is inserted
    // so that the plain four-year rule also covers 2100, which is not a leap year.
    localparam logic [15:0] SKIP_2100_FEB29   = 16'd47541;
    localparam logic [7:0]  YEAR_BASE         = 8'd68;

    localparam logic [3:0]  MONTH_DEC = 4'd11;
    localparam logic [3:0]  MONTH_FEB = 4'd1;

    // Result of the shared subtract and compare unit.
    typedef struct packed {
        logic [31:0] diff;
        logic        ge;
    } sub_res_t;

    // Length of a month, month counted from 0 for January.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd1:                   len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                default:                len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/ntpcal_in_if.sv
// Input channel carrying one raw NTP seconds word.
`default_nettype none
interface ntpcal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ntp_seconds_raw;

    modport source (output valid, output ntp_seconds_raw, input ready);
    modport sink   (input valid, input ntp_seconds_raw, output ready);
endinterface
`default_nettype wire

>>> hdl/ntpcal_out_if.sv
// Output channel carrying one calendar date and time word.
`default_nettype none
interface ntpcal_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] year_since_1900;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;

    modport source (output valid, output year_since_1900, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year_since_1900, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface
`default_nettype wire

>>> hdl/ntpcal_cfg_if.sv
// Configuration write channel carrying the timezone offset register.
`default_nettype none
interface ntpcal_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] tz_offset_seconds;

    modport source (output valid, output tz_offset_seconds, input ready);
    modport sink   (input valid, input tz_offset_seconds, output ready);
endinterface
`default_nettype wire

>>> hdl/ntp_epoch_to_calendar.sv
// A result word is ready once the year and month walks end, whose length varies, and it waits
// in the month state while the previous result word is still held.
// One shared subtractor runs restoring divisions for days, hours, minutes and four-year
// groups, then year and month walks.
// The input is not ready while a word is in work; a finished result waits in the
// output register while the next word is taken.
// Reset: asynchronous, active low; clears the sequencer, output valid and timezone to 0.
`default_nettype none
module ntp_epoch_to_calendar
    import ntpcal_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    ntpcal_in_if.sink   ntp_in,
    ntpcal_out_if.source cal_out,
    ntpcal_cfg_if.sink  cfg
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFS   = 4'd1;
    localparam logic [3:0] S_DAY   = 4'd2;
    localparam logic [3:0] S_HOUR  = 4'd3;
    localparam logic [3:0] S_MIN   = 4'd4;
    localparam logic [3:0] S_EPOCH = 4'd5;
    localparam logic [3:0] S_QUAD  = 4'd6;
    localparam logic [3:0] S_YEAR  = 4'd7;
    localparam logic [3:0] S_MONTH = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [17:0] tz_reg;

    logic [31:0] acc_reg, acc_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  quad_reg, quad_next;
    logic [1:0]  yq_reg, yq_next;
    logic [3:0]  mon_reg, mon_next;

    logic [7:0]  o_year_reg, o_year_next;
    logic [3:0]  o_month_reg, o_month_next;
    logic [4:0]  o_day_reg, o_day_next;
    logic [4:0]  o_hour_reg, o_hour_next;
    logic [5:0]  o_min_reg, o_min_next;
    logic [5:0]  o_sec_reg, o_sec_next;

    logic [31:0] raw_swapped;
    logic [31:0] ofs_operand;
    logic [31:0] operand;
    logic [15:0] quo_shift;
    logic        leap;
    logic        out_free;
    sub_res_t    sub;

    assign cfg.ready    = 1'b1;
    assign ntp_in.ready = (state_reg == S_IDLE);

    assign cal_out.valid           = out_valid_reg;
    assign cal_out.year_since_1900 = o_year_reg;
    assign cal_out.month           = o_month_reg;
    assign cal_out.day             = o_day_reg;
    assign cal_out.hour            = o_hour_reg;
    assign cal_out.minute          = o_min_reg;
    assign cal_out.second          = o_sec_reg;

    // Restore byte order; fold the era offset and the timezone into one subtrahend.
    assign raw_swapped = {ntp_in.ntp_seconds_raw[7:0], ntp_in.ntp_seconds_raw[15:8],
                          ntp_in.ntp_seconds_raw[23:16], ntp_in.ntp_seconds_raw[31:24]};
    assign ofs_operand = NTP_UNIX_DELTA - {{(32 - TZ_W){tz_reg[TZ_W - 1]}}, tz_reg};

    assign leap      = (yq_reg == 2'd0);
    assign out_free  = !out_valid_reg || cal_out.ready;
    assign quo_shift = {quo_reg[14:0], sub.ge};

    // Operand selection for the shared unit.
    always_comb
    begin
        unique case (state_reg)
            S_OFS:   operand = ofs_operand;
            S_DAY:   operand = SECS_PER_DAY << step_reg;
            S_HOUR:  operand = SECS_PER_HOUR << step_reg;
            S_MIN:   operand = SECS_PER_MIN << step_reg;
            S_QUAD:  operand = DAYS_PER_QUAD << step_reg;
            S_YEAR:  operand = leap ? 32'd366 : 32'd365;
            S_MONTH: operand = {27'd0, month_len(mon_reg, leap)};
            default: operand = 32'd0;
        endcase
    end

    ntpcal_sub_unit u_sub (
        .a   (acc_reg),
        .b   (operand),
        .res (sub)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        days_next      = days_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        quad_next      = quad_reg;
        yq_next        = yq_reg;
        mon_next       = mon_reg;
        o_year_next    = o_year_reg;
        o_month_next   = o_month_reg;
        o_day_next     = o_day_reg;
        o_hour_next    = o_hour_reg;
        o_min_next     = o_min_reg;
        o_sec_next     = o_sec_reg;

        if (out_valid_reg && cal_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (ntp_in.valid)
                begin
                    acc_next   = raw_swapped;
                    state_next = S_OFS;
                end
            end
            S_OFS:
            begin
                acc_next   = sub.diff;
                step_next  = 4'd15;
                state_next = S_DAY;
            end
            S_DAY, S_HOUR, S_MIN, S_QUAD:
            begin
                // One restoring division step.
                if (sub.ge)
                begin
                    acc_next = sub.diff;
                end
                quo_next  = quo_shift;
                step_next = step_reg - 4'd1;
                if (step_reg == 4'd0)
                begin
                    unique case (state_reg)
                        S_DAY:
                        begin
                            days_next  = quo_shift;
                            step_next  = 4'd4;
                            state_next = S_HOUR;
                        end
                        S_HOUR:
                        begin
                            hour_next  = quo_shift[4:0];
                            step_next  = 4'd5;
                            state_next = S_MIN;
                        end
                        S_MIN:
                        begin
                            min_next   = quo_shift[5:0];
                            sec_next   = sub.ge ? sub.diff[5:0] : acc_reg[5:0];
                            state_next = S_EPOCH;
                        end
                        default:
                        begin
                            quad_next  = quo_shift[5:0];
                            yq_next    = 2'd0;
                            state_next = S_YEAR;
                        end
                    endcase
                end
            end
            S_EPOCH:
            begin
                // Rebase the day count to 1968 and insert the phantom leap day of 2100.
                acc_next   = {16'd0, days_reg + DAYS_1968_TO_1970
                              + {15'd0, (days_reg >= SKIP_2100_FEB29)}};
                step_next  = 4'd5;
                state_next = S_QUAD;
            end
            S_YEAR:
            begin
                if (sub.ge)
                begin
                    acc_next = sub.diff;
                    yq_next  = yq_reg + 2'd1;
                end
                else
                begin
                    mon_next   = 4'd0;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (sub.ge && (mon_reg != MONTH_DEC))
                begin
                    acc_next = sub.diff;
                    mon_next = mon_reg + 4'd1;
                end
                else if (out_free)
                begin
                    o_year_next    = YEAR_BASE + {quad_reg, yq_reg};
                    o_month_next   = mon_reg + 4'd1;
                    o_day_next     = acc_reg[4:0] + 5'd1;
                    o_hour_next    = hour_reg;
                    o_min_next     = min_reg;
                    o_sec_next     = sec_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the timezone register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            tz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                tz_reg <= cfg.tz_offset_seconds;
            end
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        quo_reg     <= quo_next;
        days_reg    <= days_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        quad_reg    <= quad_next;
        yq_reg      <= yq_next;
        mon_reg     <= mon_next;
        o_year_reg  <= o_year_next;
        o_month_reg <= o_month_next;
        o_day_reg   <= o_day_next;
        o_hour_reg  <= o_hour_next;
        o_min_reg   <= o_min_next;
        o_sec_reg   <= o_sec_next;
    end

`ifndef SYNTH
    // Once a word is taken, the input stays closed while it is in work.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ntp_in.valid && ntp_in.ready |=> !ntp_in.ready)
        else $error("input ready right after an accepted word");

    // A delivered month lies in 1 to 12.
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_out.valid |-> (cal_out.month >= 4'd1) && (cal_out.month <= 4'd12))
        else $error("month out of range");

    // A delivered time of day is well formed.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_out.valid |-> (cal_out.hour < 5'd24) && (cal_out.minute < 6'd60)
                          && (cal_out.second < 6'd60))
        else $error("time of day out of range");

    // A delivered day is nonzero and fits its month as long as in a leap year.
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_out.valid |-> (cal_out.day != 5'd0)
            && (cal_out.day <= month_len(cal_out.month - 4'd1, 1'b1)))
        else $error("day out of range for its month");
`endif

endmodule
`default_nettype wire

>>> hdl/ntpcal_sub_unit.sv
// Shared 32-bit subtract and compare unit used by the offset, division and walk steps.
`default_nettype none
module ntpcal_sub_unit
    import ntpcal_pkg::*;
(
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output sub_res_t         res
);

    logic [32:0] wide;

    // One wide subtract; the missing borrow tells a is at least b.
    always_comb
    begin
        wide     = {1'b0, a} - {1'b0, b};
        res.diff = wide[31:0];
        res.ge   = ~wide[32];
    end

endmodule
`default_nettype wire
